@@ rtl/i2p_pkg.sv @@
// Package with shared types, constants and a helper function for the integer-to-posit converter.
`timescale 1ns / 1ps

package i2p_pkg;

    // Width of the integer operand and of the posit result.
    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned K_W    = 3;

    // Encoding constants for a 32-bit posit with two exponent bits.
    localparam logic [DATA_W-1:0] MAG_LIMIT   = 32'd2147483135;
    localparam logic [DATA_W-1:0] NEG_LIMIT   = 32'h8000_0201;
    localparam logic [DATA_W-1:0] POS_SAT     = 32'h7FB0_0000;
    localparam logic [DATA_W-1:0] NEG_SAT     = 32'h8050_0000;
    localparam logic [DATA_W-1:0] REGIME_ALL  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] REGIME_MASK = 32'h3FFF_FFFF;
    localparam logic [DATA_W-1:0] TOP_BIT     = 32'h8000_0000;
    localparam logic [DATA_W-1:0] GUARD_BASE  = 32'h0000_0008;

    // Special-case flags that travel with each request.
    typedef struct packed {
        logic neg;
        logic sat_pos;
        logic sat_neg;
        logic zero;
    } i2p_flags_t;

    // Normalized operand handed from the front end to the packing stages.
    typedef struct packed {
        logic               valid;
        i2p_flags_t         flags;
        logic [POS_W-1:0]   pos;
        logic [DATA_W-1:0]  frac;
    } i2p_norm_t;

    // Position of the leading one; the result for a zero word is not used.
    function automatic logic [POS_W-1:0] lead_one_pos(input logic [DATA_W-1:0] value);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < DATA_W; i++)
        begin
            if (value[i])
            begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

@@ rtl/int32_to_posit32_convert_core.sv @@
// Top level of the signed 32-bit integer to 32-bit posit (es = 2) converter.
`timescale 1ns / 1ps

// Usage:
//   A request is taken at a rising clock edge where start is high and busy is
//   low; int_value carries the signed integer to convert. busy is always low,
//   so a new request can be issued in every cycle.
//   Each request gives exactly one result: posit_bits is valid for one cycle,
//   marked by done, and results come out in request order.
//   Throughput is one request per cycle; the work is split into six register
//   stages (magnitude, leading-one search, normalizing shift, field packing,
//   rounding increment, sign and special-case select).
//   Reset clears all valid bits, so no result appears for requests that were
//   in flight when rst_n went low; no other state is kept.
//   The receiver cannot stall: every result must be taken in its done cycle.
//   Negative integers give the two's complement of the positive encoding;
//   magnitudes near 2^31 saturate to the encodings of plus and minus 2^31.

module int32_to_posit32_convert_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [i2p_pkg::DATA_W-1:0] int_value,
    output logic                              done,
    output logic [i2p_pkg::DATA_W-1:0]        posit_bits
);

    i2p_pkg::i2p_norm_t norm;
    logic               accept;

    // The pipeline never stalls, so requests are always taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Magnitude, leading-one search and normalization.
    i2p_normalize u_normalize (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .int_value (int_value),
        .norm      (norm)
    );

    // Field packing, rounding and sign handling.
    i2p_pack_round u_pack_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .norm       (norm),
        .done       (done),
        .posit_bits (posit_bits)
    );

endmodule

@@ rtl/i2p_normalize.sv @@
// Front end: magnitude, special-case detection, leading-one search and normalizing shift.
`timescale 1ns / 1ps

module i2p_normalize (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [i2p_pkg::DATA_W-1:0] int_value,
    output i2p_pkg::i2p_norm_t            norm
);

    logic [i2p_pkg::DATA_W-1:0] x;
    logic                       x_neg;

    // Stage 1 registers.
    logic                       v1_reg;
    i2p_pkg::i2p_flags_t        flags1_reg;
    i2p_pkg::i2p_flags_t        flags1_next;
    logic [i2p_pkg::DATA_W-1:0] mag1_reg;
    logic [i2p_pkg::DATA_W-1:0] mag1_next;

    // Stage 2 registers.
    logic                       v2_reg;
    i2p_pkg::i2p_flags_t        flags2_reg;
    logic [i2p_pkg::DATA_W-1:0] mag2_reg;
    logic [i2p_pkg::POS_W-1:0]  pos2_reg;
    logic [i2p_pkg::POS_W-1:0]  pos2_next;

    // Stage 3 registers.
    logic                       v3_reg;
    i2p_pkg::i2p_flags_t        flags3_reg;
    logic [i2p_pkg::POS_W-1:0]  pos3_reg;
    logic [i2p_pkg::DATA_W-1:0] frac3_reg;
    logic [i2p_pkg::DATA_W-1:0] frac3_next;

    // Stage 1: take the magnitude and classify the special cases.
    always_comb
    begin
        x                   = $unsigned(int_value);
        x_neg               = x[i2p_pkg::DATA_W-1];
        mag1_next           = x_neg ? (i2p_pkg::DATA_W'(0) - x) : x;
        flags1_next.neg     = x_neg;
        flags1_next.sat_neg = x_neg && (x < i2p_pkg::NEG_LIMIT);
        flags1_next.sat_pos = !x_neg && (x > i2p_pkg::MAG_LIMIT);
        flags1_next.zero    = (x == '0);
    end

    // Stage 2: find the leading one of the magnitude.
    assign pos2_next = i2p_pkg::lead_one_pos(mag1_reg);

    // Stage 3: shift the leading one up to the top bit.
    assign frac3_next = mag2_reg << (i2p_pkg::POS_W'(i2p_pkg::DATA_W - 1) - pos2_reg);

    // Valid bits of the three front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload registers of the three front stages.
    always_ff @(posedge clk)
    begin
        flags1_reg <= flags1_next;
        mag1_reg   <= mag1_next;
        flags2_reg <= flags1_reg;
        mag2_reg   <= mag1_reg;
        pos2_reg   <= pos2_next;
        flags3_reg <= flags2_reg;
        pos3_reg   <= pos2_reg;
        frac3_reg  <= frac3_next;
    end

    assign norm.valid = v3_reg;
    assign norm.flags = flags3_reg;
    assign norm.pos   = pos3_reg;
    assign norm.frac  = frac3_reg;

    // A request in stage 1 moves on to stage 2 without a gap.
    a_v1_to_v2: assert property (@(posedge clk) disable iff (!rst_n) v1_reg |=> v2_reg)
        else $error("stage 1 request did not reach stage 2");

    // The leading-one position points at a set bit of a nonzero magnitude.
    a_lead_one: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && (mag2_reg != '0)) |-> mag2_reg[pos2_reg])
        else $error("leading-one position does not point at a set bit");

    // A nonzero magnitude comes out with its top bit set after the shift.
    a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !flags3_reg.zero && !flags3_reg.sat_neg) |-> frac3_reg[i2p_pkg::DATA_W-1])
        else $error("normalized fraction lacks its leading one");

endmodule

@@ rtl/i2p_pack_round.sv @@
// Back end: regime and exponent packing, round to nearest even, sign and special-case select.
`timescale 1ns / 1ps

module i2p_pack_round (
    input  logic                          clk,
    input  logic                          rst_n,
    input  i2p_pkg::i2p_norm_t            norm,
    output logic                          done,
    output logic [i2p_pkg::DATA_W-1:0]    posit_bits
);

    logic [i2p_pkg::K_W-1:0]    k;
    logic [i2p_pkg::DATA_W-1:0] expo;
    logic [i2p_pkg::DATA_W-1:0] regime;
    logic [i2p_pkg::DATA_W-1:0] frac_low;
    logic [i2p_pkg::DATA_W-1:0] guard;

    // Stage 4 registers.
    logic                       v4_reg;
    i2p_pkg::i2p_flags_t        flags4_reg;
    logic [i2p_pkg::DATA_W-1:0] bits4_reg;
    logic [i2p_pkg::DATA_W-1:0] bits4_next;
    logic                       rnd4_reg;
    logic                       rnd4_next;

    // Stage 5 registers.
    logic                       v5_reg;
    i2p_pkg::i2p_flags_t        flags5_reg;
    logic [i2p_pkg::DATA_W-1:0] sum5_reg;
    logic [i2p_pkg::DATA_W-1:0] sum5_next;

    // Stage 6 (output) registers.
    logic                       done_reg;
    logic [i2p_pkg::DATA_W-1:0] posit_bits_reg;
    logic [i2p_pkg::DATA_W-1:0] posit_bits_next;

    // Stage 4: build the regime, exponent and fraction fields and the round decision.
    always_comb
    begin
        k          = norm.pos[i2p_pkg::POS_W-1 -: i2p_pkg::K_W];
        expo       = {{(i2p_pkg::DATA_W-2){1'b0}}, norm.pos[1:0]}
                     << (i2p_pkg::POS_W'(27) - i2p_pkg::POS_W'(k));
        regime     = i2p_pkg::REGIME_ALL ^ (i2p_pkg::REGIME_MASK >> k);
        frac_low   = norm.frac & ~i2p_pkg::TOP_BIT;
        bits4_next = regime | expo | (frac_low >> (i2p_pkg::POS_W'(k) + i2p_pkg::POS_W'(4)));
        guard      = i2p_pkg::GUARD_BASE << k;
        rnd4_next  = ((guard & frac_low) != '0)
                     && ((((guard - i2p_pkg::DATA_W'(1)) & frac_low) != '0)
                         || (((guard << 1) & frac_low) != '0));
    end

    // Stage 5: apply the rounding increment.
    assign sum5_next = bits4_reg + i2p_pkg::DATA_W'(rnd4_reg);

    // Stage 6: select the special cases and apply the sign.
    always_comb
    begin
        if (flags5_reg.sat_neg)
        begin
            posit_bits_next = i2p_pkg::NEG_SAT;
        end
        else if (flags5_reg.sat_pos)
        begin
            posit_bits_next = i2p_pkg::POS_SAT;
        end
        else if (flags5_reg.zero)
        begin
            posit_bits_next = '0;
        end
        else if (flags5_reg.neg)
        begin
            posit_bits_next = i2p_pkg::DATA_W'(0) - sum5_reg;
        end
        else
        begin
            posit_bits_next = sum5_reg;
        end
    end

    // Valid bits of the back stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v4_reg   <= norm.valid;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    // Payload registers of the back stages.
    always_ff @(posedge clk)
    begin
        flags4_reg     <= norm.flags;
        bits4_reg      <= bits4_next;
        rnd4_reg       <= rnd4_next;
        flags5_reg     <= flags4_reg;
        sum5_reg       <= sum5_next;
        posit_bits_reg <= posit_bits_next;
    end

    assign done       = done_reg;
    assign posit_bits = posit_bits_reg;

    // A request in the packing stage always produces a result, through stage 5 and the output register.
    a_v4_to_done: assert property (@(posedge clk) disable iff (!rst_n) v4_reg |=> ##1 done_reg)
        else $error("packed request did not produce a result");

    // The two saturation cases never apply to the same request.
    a_sat_excl: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> !(flags5_reg.sat_pos && flags5_reg.sat_neg))
        else $error("both saturation flags set");

    // A positive, non-saturated result never has its sign bit set.
    a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !flags5_reg.neg) |=> !posit_bits_reg[i2p_pkg::DATA_W-1])
        else $error("positive input gave a negative posit");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the signed 32-bit integer to 32-bit posit (es = 2) converter.
`timescale 1ns / 1ps

module tb;

    // Idle cycles with nothing taken in or given out before the run is declared hung.
    localparam int HANG_LIMIT   = 1000;
    // Cycles allowed after the last result for anything unexpected to come out.
    localparam int SETTLE_TICKS = 12;
    localparam int RANDOM_COUNT = 1825;

    // Queue of expected posit patterns, one per accepted request, in request order.
    class posit_scoreboard;
        logic [i2p_pkg::DATA_W-1:0] want_q[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // Encoding of one integer, rounded to nearest with ties to even.
        function logic [i2p_pkg::DATA_W-1:0] encode_int(logic [i2p_pkg::DATA_W-1:0] x);
            logic [i2p_pkg::DATA_W-1:0] mag;
            logic [i2p_pkg::DATA_W-1:0] frac;
            logic [i2p_pkg::DATA_W-1:0] bits;
            logic [i2p_pkg::DATA_W-1:0] guard;
            logic [i2p_pkg::DATA_W-1:0] expo;
            logic                       neg;
            int                         lead;
            int                         k;
            neg = x[i2p_pkg::DATA_W-1];
            // Values from -2^31 up to just below -2147483135 pin to the negative limit.
            if (neg && x < i2p_pkg::NEG_LIMIT)
            begin
                return i2p_pkg::NEG_SAT;
            end
            mag = neg ? -x : x;
            if (mag > i2p_pkg::MAG_LIMIT)
            begin
                bits = i2p_pkg::POS_SAT;
            end
            else if (mag < 2)
            begin
                bits = mag << 30;
            end
            else
            begin
                lead = 0;
                for (int i = 0; i < i2p_pkg::DATA_W; i++)
                begin
                    if (mag[i])
                    begin
                        lead = i;
                    end
                end
                frac  = mag << (31 - lead);
                k     = lead >> 2;
                expo  = i2p_pkg::DATA_W'(lead & 3) << (27 - k);
                frac  = frac ^ i2p_pkg::TOP_BIT;
                bits  = (i2p_pkg::REGIME_ALL ^ (i2p_pkg::REGIME_MASK >> k)) | expo
                        | (frac >> (k + 4));
                guard = i2p_pkg::GUARD_BASE << k;
                // A set guard bit rounds up unless it is an exact tie with an even LSB.
                if ((guard & frac) != 0)
                begin
                    if (((guard - 1) & frac) != 0 || ((guard << 1) & frac) != 0)
                    begin
                        bits = bits + 1;
                    end
                end
            end
            return neg ? -bits : bits;
        endfunction

        function void note_request(logic [i2p_pkg::DATA_W-1:0] value);
            want_q.push_back(encode_int(value));
        endfunction

        function void check_result(logic [i2p_pkg::DATA_W-1:0] got);
            logic [i2p_pkg::DATA_W-1:0] want;
            if (want_q.size() == 0)
            begin
                $error("posit_bits: result with no request pending, actual %h", got);
                errors++;
                return;
            end
            want = want_q.pop_front();
            if (got !== want)
            begin
                $error("posit_bits mismatch: expected %h, actual %h", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [i2p_pkg::DATA_W-1:0] int_value;
    logic                       done;
    logic [i2p_pkg::DATA_W-1:0] posit_bits;

    posit_scoreboard            sb;
    int                         quiet_ticks = 0;

    int32_to_posit32_convert_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .int_value  (int_value),
        .done       (done),
        .posit_bits (posit_bits)
    );

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watch both sides of the block at every edge and score what moves.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            sb.note_request(int_value);
        end
        if (rst_n && done)
        begin
            sb.check_result(posit_bits);
        end
        if ((rst_n && start && !busy) || (rst_n && done))
        begin
            quiet_ticks <= 0;
        end
        else
        begin
            quiet_ticks <= quiet_ticks + 1;
        end
    end

    // Hang detection: nothing accepted on either side for too long.
    always @(posedge clk)
    begin
        if (quiet_ticks >= HANG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Hold one request until the block takes it.
    task automatic send_request(input logic [i2p_pkg::DATA_W-1:0] value);
        start     <= 1'b1;
        int_value <= value;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Leave the request line low for a number of cycles, with junk on the operand.
    task automatic idle_for(input int n);
        if (n > 0)
        begin
            start     <= 1'b0;
            int_value <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop issuing until every expected result has come out.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly back-to-back, sometimes short gaps, rarely long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            return 0;
        end
        else if (roll < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (roll < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(20, 60);
    endfunction

    // Random operand drawn from classes that stress different parts of the encoding.
    function automatic logic [i2p_pkg::DATA_W-1:0] pick_operand();
        logic [i2p_pkg::DATA_W-1:0] value;
        int                         roll;
        int                         width;
        int                         cut;
        roll  = $urandom_range(0, 99);
        width = $urandom_range(1, 32);
        value = $urandom & (32'hFFFF_FFFF >> (32 - width));
        if (roll < 25)
        begin
            // Full-range word.
            value = $urandom;
        end
        else if (roll < 55)
        begin
            // Magnitude of random width, so every regime length shows up.
            if ($urandom_range(0, 1) == 1)
            begin
                value = -value;
            end
        end
        else if (roll < 75)
        begin
            // Low bits forced into an exact tie just below the kept fraction.
            cut   = $urandom_range(1, 12);
            value = (value & ~((32'h1 << cut) - 1)) | (32'h1 << (cut - 1));
            if ($urandom_range(0, 1) == 1)
            begin
                value = -value;
            end
        end
        else if (roll < 80)
        begin
            // Runs of ones that carry through the exponent and regime on rounding.
            value = 32'hFFFF_FFFF >> (32 - width);
            if ($urandom_range(0, 1) == 1)
            begin
                value = -value;
            end
        end
        else if (roll < 90)
        begin
            // Close to the saturation thresholds on either side.
            value = i2p_pkg::MAG_LIMIT - 32'($urandom_range(0, 1100)) + 32'd550;
            if ($urandom_range(0, 1) == 1)
            begin
                value = -value;
            end
        end
        else
        begin
            // Small signed values around zero.
            value = 32'($urandom_range(0, 40)) - 32'd20;
        end
        return value;
    endfunction

    initial
    begin
        logic [i2p_pkg::DATA_W-1:0] directed_q[$];
        bit                         steady;
        sb          = new();
        rst_n      <= 1'b0;
        start      <= 1'b0;
        int_value  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero, plus and minus one, small values, both saturation edges, ties and carries.
        directed_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFE, 32'd3, 32'd16,
                       32'd17, i2p_pkg::MAG_LIMIT, i2p_pkg::MAG_LIMIT + 32'd1,
                       32'h7FFF_FFFF, i2p_pkg::NEG_LIMIT, i2p_pkg::NEG_LIMIT - 32'd1,
                       i2p_pkg::TOP_BIT, 32'h4000_0200,
                       32'h4000_0600, 32'h4000_0201, 32'h0FFF_FFFF, 32'hF000_0001,
                       32'h0000_FFFF, 32'h00FF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                       -32'h4000_0600};
        foreach (directed_q[i])
        begin
            send_request(directed_q[i]);
            idle_for(i % 3);
        end
        drain_results();

        // Random requests in segments, some with no gaps at all.
        steady = 1'b0;
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i % 100 == 0)
            begin
                steady = ($urandom_range(0, 3) == 0);
            end
            send_request(pick_operand());
            if (i % 400 == 399)
            begin
                drain_results();
            end
            else if (!steady)
            begin
                idle_for(pick_gap());
            end
        end

        // Let the pipeline empty, then watch for stray results.
        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("posit_bits: %0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/i2p_pkg.sv
rtl/i2p_normalize.sv
rtl/i2p_pack_round.sv
rtl/int32_to_posit32_convert_core.sv
tb/tb.sv
